### rtl/core/k3c_pkg.sv
// Package of the 3x3 convolution filter: shared widths, the work record that
// travels from the window front end to the arithmetic back end, kernel kinds.
// No dependencies.
package k3c_pkg;

    localparam int PIX_W      = 8;
    localparam int WIDTH_W    = 11;
    localparam int HEIGHT_W   = 13;
    localparam int ROW_W      = 24;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;
    localparam int CNT_ROW_W  = 14;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KERNEL_TOP    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_KERNEL_MIDDLE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_KERNEL_BOTTOM = 3'd4;

    localparam logic [WIDTH_W-1:0]  RESET_WIDTH  = 11'd1024;
    localparam logic [HEIGHT_W-1:0] RESET_HEIGHT = 13'd1024;
    localparam logic [ROW_W-1:0]    RESET_KROW   = 24'h010101;

    // Queue between front and back end.
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // Division by nine as multiply and shift; exact for sums below 2296.
    localparam logic [11:0] RECIP_9     = 12'd3641;
    localparam int          RECIP_SHIFT = 15;

    localparam int MEAN_K   [9] = '{1, 1, 1, 1, 1, 1, 1, 1, 1};
    localparam int GAUSS_K  [9] = '{1, 2, 1, 2, 4, 2, 1, 2, 1};
    localparam int HSOBEL_K [9] = '{1, 2, 1, 0, 0, 0, -1, -2, -1};
    localparam int VSOBEL_K [9] = '{-1, 0, 1, -2, 0, 2, -1, 0, 1};

    typedef enum logic [1:0] {
        KIND_PLAIN,
        KIND_MEAN,
        KIND_GAUSS,
        KIND_SOBEL
    } kind_t;

    // One center position: its window (top row first, left first) and which
    // window rows and columns fall outside the image.
    typedef struct packed {
        logic [8:0][PIX_W-1:0] pix;
        logic                  top_off;
        logic                  bottom_off;
        logic                  left_off;
        logic                  right_off;
        logic                  frame_end;
    } work_t;

    function automatic logic [CNT_ROW_W-1:0] row_inc(input logic [CNT_ROW_W-1:0] r);
        row_inc = (&r) ? r : r + 1'b1;
    endfunction

endpackage

### rtl/core/k3c_stream_if.sv
// Stream channels of the 3x3 convolution filter: pixel requests in and
// filtered results out. Depends on k3c_pkg.
interface k3c_pix_if;
    logic                      valid;
    logic                      ready;
    logic [k3c_pkg::PIX_W-1:0] pixel_in;
    logic                      flush;

    modport source (output valid, output pixel_in, output flush, input ready);
    modport sink (input valid, input pixel_in, input flush, output ready);
endinterface

interface k3c_res_if;
    logic                      valid;
    logic                      ready;
    logic [k3c_pkg::PIX_W-1:0] pixel_out;
    logic                      frame_end;

    modport source (output valid, output pixel_out, output frame_end, input ready);
    modport sink (input valid, input pixel_out, input frame_end, output ready);
endinterface

### rtl/core/k3c_front.sv
// Front end: position counters, two line stores and the 3x3 window. Each
// request that completes a center pushes one work record. Uses k3c_pkg.
module k3c_front #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                            clk,
    input  logic                            rst_n,
    k3c_pix_if.sink                         pixels,
    input  logic [k3c_pkg::WIDTH_W-1:0]     image_width,
    input  logic [k3c_pkg::HEIGHT_W-1:0]    image_height,
    input  logic [k3c_pkg::QCNT_W-1:0]      q_count,
    output logic                            push,
    output k3c_pkg::work_t                  work
);
    import k3c_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int RW = CNT_ROW_W;

    logic [PIX_W-1:0] upper_mem [MAX_WIDTH];
    logic [PIX_W-1:0] lower_mem [MAX_WIDTH];

    logic [CW-1:0] in_col_reg, in_col_next, out_col_reg, out_col_next;
    logic [RW-1:0] in_row_reg, in_row_next, out_row_reg, out_row_next;

    logic             b_valid_reg;
    logic             b_started_reg;
    logic [CW-1:0]    b_x_reg;
    logic [PIX_W-1:0] b_v_reg;
    logic             b_top_reg, b_bottom_reg, b_left_reg, b_right_reg, b_end_reg;
    logic [PIX_W-1:0] up_rd_reg, lo_rd_reg;
    logic [8:0][PIX_W-1:0] win_reg, win_next;

    logic [WW-1:0]       w_eff;
    logic [HEIGHT_W-1:0] h_eff;
    logic [QCNT_W:0]     pending;
    logic                accept;

    logic [CW-1:0]    ic0, oc0;
    logic [RW-1:0]    ir0, or0;
    logic [WW-1:0]    ic1, oc1;
    logic [PIX_W-1:0] v;
    logic             started, top_off, bottom_off, left_off, right_off, fr_end;

    assign pending      = {1'b0, q_count} + {{QCNT_W{1'b0}}, b_valid_reg};
    assign pixels.ready = pending < (QCNT_W + 1)'(QDEPTH);
    assign accept       = pixels.valid && pixels.ready;

    always_comb
    begin
        if (int'(image_width) > MAX_WIDTH)
        begin
            w_eff = WW'(MAX_WIDTH);
        end
        else if (image_width < 11'd3)
        begin
            w_eff = WW'(3);
        end
        else
        begin
            w_eff = WW'(image_width);
        end
        h_eff = (image_height < 13'd3) ? 13'd3 : image_height;
    end

    always_comb
    begin
        // A column left at or past the width (size change) wraps first.
        if (WW'(in_col_reg) >= w_eff)
        begin
            ic0 = '0;
            ir0 = row_inc(in_row_reg);
        end
        else
        begin
            ic0 = in_col_reg;
            ir0 = in_row_reg;
        end
        v = (pixels.flush || ir0 >= RW'(h_eff)) ? '0 : pixels.pixel_in;
        started = (ir0 >= RW'(2)) || (ir0 == RW'(1) && ic0 != '0);
        ic1 = WW'(ic0) + 1'b1;
        if (ic1 >= w_eff)
        begin
            in_col_next = '0;
            in_row_next = row_inc(ir0);
        end
        else
        begin
            in_col_next = CW'(ic1);
            in_row_next = ir0;
        end

        if (WW'(out_col_reg) >= w_eff)
        begin
            oc0 = '0;
            or0 = row_inc(out_row_reg);
        end
        else
        begin
            oc0 = out_col_reg;
            or0 = out_row_reg;
        end
        oc1        = WW'(oc0) + 1'b1;
        top_off    = (or0 == '0);
        bottom_off = ({1'b0, or0} + 1'b1) >= (RW + 1)'(h_eff);
        left_off   = (oc0 == '0);
        right_off  = oc1 >= w_eff;
        fr_end     = bottom_off && right_off;

        out_col_next = out_col_reg;
        out_row_next = out_row_reg;
        if (started)
        begin
            if (fr_end)
            begin
                in_col_next  = '0;
                in_row_next  = '0;
                out_col_next = '0;
                out_row_next = '0;
            end
            else if (right_off)
            begin
                out_col_next = '0;
                out_row_next = row_inc(or0);
            end
            else
            begin
                out_col_next = CW'(oc1);
                out_row_next = or0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_col_reg    <= '0;
            in_row_reg    <= '0;
            out_col_reg   <= '0;
            out_row_reg   <= '0;
            b_valid_reg   <= 1'b0;
            b_started_reg <= 1'b0;
            win_reg       <= '0;
        end
        else
        begin
            b_valid_reg <= accept;
            if (accept)
            begin
                in_col_reg    <= in_col_next;
                in_row_reg    <= in_row_next;
                out_col_reg   <= out_col_next;
                out_row_reg   <= out_row_next;
                b_started_reg <= started;
            end
            if (b_valid_reg)
            begin
                win_reg <= win_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            b_x_reg      <= ic0;
            b_v_reg      <= v;
            b_top_reg    <= top_off;
            b_bottom_reg <= bottom_off;
            b_left_reg   <= left_off;
            b_right_reg  <= right_off;
            b_end_reg    <= fr_end;
        end
    end

    // Line stores: read when the request is taken, written back in the next cycle.
    // The same column comes back only a full row later, so there is no hazard.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            up_rd_reg <= upper_mem[ic0];
            lo_rd_reg <= lower_mem[ic0];
        end
        if (b_valid_reg)
        begin
            upper_mem[b_x_reg] <= lo_rd_reg;
            lower_mem[b_x_reg] <= b_v_reg;
        end
    end

    always_comb
    begin
        win_next    = win_reg;
        win_next[0] = win_reg[1];
        win_next[1] = win_reg[2];
        win_next[2] = up_rd_reg;
        win_next[3] = win_reg[4];
        win_next[4] = win_reg[5];
        win_next[5] = lo_rd_reg;
        win_next[6] = win_reg[7];
        win_next[7] = win_reg[8];
        win_next[8] = b_v_reg;
    end

    assign push            = b_valid_reg && b_started_reg;
    assign work.pix        = win_next;
    assign work.top_off    = b_top_reg;
    assign work.bottom_off = b_bottom_reg;
    assign work.left_off   = b_left_reg;
    assign work.right_off  = b_right_reg;
    assign work.frame_end  = b_end_reg;

endmodule

### rtl/core/k3c_queue.sv
// Short queue of work records between the front and back ends.
// Uses k3c_pkg.
module k3c_queue (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    input  k3c_pkg::work_t             wr_data,
    input  logic                       pop,
    output logic                       rd_valid,
    output k3c_pkg::work_t             rd_data,
    output logic [k3c_pkg::QCNT_W-1:0] count
);
    import k3c_pkg::*;

    work_t             slot_mem [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic              do_pop;

    assign rd_valid = count_reg != '0;
    assign rd_data  = slot_mem[rd_ptr_reg];
    assign count    = count_reg;
    assign do_pop   = pop && rd_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (!push && do_pop)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_mem[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

### rtl/core/k3c_back.sv
// Back end: nine products, row sums, total, kernel dependent scaling and
// clamping, with the output register. Uses k3c_pkg and k3c_res_if.
module k3c_back #(
    parameter int COEF_BITS = 8
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic [k3c_pkg::ROW_W-1:0]  kernel_row_top,
    input  logic [k3c_pkg::ROW_W-1:0]  kernel_row_middle,
    input  logic [k3c_pkg::ROW_W-1:0]  kernel_row_bottom,
    input  logic                       q_valid,
    input  k3c_pkg::work_t             work,
    output logic                       pop,
    k3c_res_if.source                  results
);
    import k3c_pkg::*;

    localparam int EXT = 3 * COEF_BITS;
    localparam int PW  = COEF_BITS + PIX_W + 1;
    localparam int RSW = PW + 2;
    localparam int SW  = PW + 4;

    logic [EXT-1:0]              ext_rows [3];
    logic signed [COEF_BITS-1:0] coef [9];
    logic                        is_mean, is_gauss, is_hsobel, is_vsobel;
    kind_t                       kind_reg, kind_next;

    logic                 en;
    logic                 v1_reg, v2_reg, v3_reg, out_valid_reg;
    logic                 e1_reg, e2_reg, e3_reg, out_end_reg;
    logic signed [PW-1:0]  prod_reg [9];
    logic signed [PW-1:0]  prod_next [9];
    logic signed [RSW-1:0] rsum_reg [3];
    logic signed [SW-1:0]  sum_reg;
    logic [PIX_W-1:0]      out_pix_reg, pix_next;
    logic [23:0]           mean_prod;
    logic signed [SW-1:0]  q, mag;

    assign ext_rows[0] = EXT'(kernel_row_top);
    assign ext_rows[1] = EXT'(kernel_row_middle);
    assign ext_rows[2] = EXT'(kernel_row_bottom);

    always_comb
    begin
        is_mean   = 1'b1;
        is_gauss  = 1'b1;
        is_hsobel = 1'b1;
        is_vsobel = 1'b1;
        for (int n = 0; n < 9; n++)
        begin
            coef[n] = $signed(ext_rows[n / 3][(n % 3) * COEF_BITS +: COEF_BITS]);
            if (int'(coef[n]) != MEAN_K[n])   is_mean   = 1'b0;
            if (int'(coef[n]) != GAUSS_K[n])  is_gauss  = 1'b0;
            if (int'(coef[n]) != HSOBEL_K[n]) is_hsobel = 1'b0;
            if (int'(coef[n]) != VSOBEL_K[n]) is_vsobel = 1'b0;
        end
        priority if (is_mean)                kind_next = KIND_MEAN;
        else if (is_gauss)                   kind_next = KIND_GAUSS;
        else if (is_hsobel || is_vsobel)     kind_next = KIND_SOBEL;
        else                                 kind_next = KIND_PLAIN;
    end

    // Window taps outside the image contribute nothing.
    always_comb
    begin
        for (int n = 0; n < 9; n++)
        begin
            if ((n / 3 == 0 && work.top_off) || (n / 3 == 2 && work.bottom_off) ||
                (n % 3 == 0 && work.left_off) || (n % 3 == 2 && work.right_off))
            begin
                prod_next[n] = '0;
            end
            else
            begin
                prod_next[n] = PW'(coef[n]) * PW'($signed({1'b0, work.pix[n]}));
            end
        end
    end

    assign en      = !out_valid_reg || results.ready;
    assign pop     = en;

    always_comb
    begin
        mean_prod = 24'(sum_reg[11:0]) * 24'(RECIP_9);
        mag       = (sum_reg < 0) ? -sum_reg : sum_reg;
        unique case (kind_reg)
            KIND_MEAN:  q = $signed(SW'(mean_prod >> RECIP_SHIFT));
            KIND_GAUSS: q = sum_reg >>> 4;
            KIND_SOBEL: q = mag >>> 2;
            KIND_PLAIN: q = sum_reg;
            default:    q = sum_reg;
        endcase
        if (q < 0)
        begin
            pix_next = '0;
        end
        else if (q > $signed(SW'(255)))
        begin
            pix_next = '1;
        end
        else
        begin
            pix_next = q[PIX_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kind_reg      <= KIND_MEAN;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            kind_reg <= kind_next;
            if (en)
            begin
                v1_reg        <= q_valid;
                v2_reg        <= v1_reg;
                v3_reg        <= v2_reg;
                out_valid_reg <= v3_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= prod_next;
            e1_reg   <= work.frame_end;
            for (int i = 0; i < 3; i++)
            begin
                rsum_reg[i] <= RSW'(prod_reg[3 * i]) + RSW'(prod_reg[3 * i + 1]) +
                               RSW'(prod_reg[3 * i + 2]);
            end
            e2_reg      <= e1_reg;
            sum_reg     <= SW'(rsum_reg[0]) + SW'(rsum_reg[1]) + SW'(rsum_reg[2]);
            e3_reg      <= e2_reg;
            out_pix_reg <= pix_next;
            out_end_reg <= e3_reg;
        end
    end

    assign results.valid     = out_valid_reg;
    assign results.pixel_out = out_pix_reg;
    assign results.frame_end = out_end_reg;

endmodule

### rtl/core/kernel3x3_convolution_filter.sv
// 3x3 convolution filter over a raster stream of 8-bit grey pixels.
//
// Channels: pixels (valid/ready, pixel_in, flush) and results (valid/ready,
// pixel_out, frame_end). A frame is width*height pixel requests followed by
// width+1 flush requests; each center position yields one result once the
// request one row and one pixel after it has been taken, in raster order,
// with frame_end set on the last center of the frame.
// One request is taken per clock while the queue has room. A result passes
// through front end, queue and an arithmetic pipe (products, row sums and
// total) ending in the output register, once its window is complete.
// When the receiver stalls, the arithmetic pipe holds and the four-entry
// queue fills; the pixel input drops ready once the queue has no room left.
// Reset clears the counters, the window and the pipe, and loads width 1024,
// height 1024 and the mean kernel. Line store contents start undefined; an
// unwritten entry only feeds window taps outside the image.
// The user must write configuration through cfg_we/cfg_index/cfg_data only while idle; the block has no check.
// Depends on k3c_pkg, k3c_stream_if, k3c_front, k3c_queue and k3c_back.
module kernel3x3_convolution_filter #(
    parameter int MAX_WIDTH = 1024,
    parameter int COEF_BITS = 8
) (
    input  logic                             clk,
    input  logic                             rst_n,
    k3c_pix_if.sink                          pixels,
    k3c_res_if.source                        results,
    input  logic                             cfg_we,
    input  logic [k3c_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [k3c_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import k3c_pkg::*;

    logic [WIDTH_W-1:0]  width_reg;
    logic [HEIGHT_W-1:0] height_reg;
    logic [ROW_W-1:0]    ktop_reg, kmid_reg, kbot_reg;

    logic              push, pop, q_valid;
    work_t             front_work, queue_work;
    logic [QCNT_W-1:0] q_count;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= RESET_WIDTH;
            height_reg <= RESET_HEIGHT;
            ktop_reg   <= RESET_KROW;
            kmid_reg   <= RESET_KROW;
            kbot_reg   <= RESET_KROW;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_IMAGE_WIDTH:   width_reg  <= cfg_data[WIDTH_W-1:0];
                REG_IMAGE_HEIGHT:  height_reg <= cfg_data[HEIGHT_W-1:0];
                REG_KERNEL_TOP:    ktop_reg   <= cfg_data[ROW_W-1:0];
                REG_KERNEL_MIDDLE: kmid_reg   <= cfg_data[ROW_W-1:0];
                REG_KERNEL_BOTTOM: kbot_reg   <= cfg_data[ROW_W-1:0];
                default:           ;
            endcase
        end
    end

    k3c_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .pixels       (pixels),
        .image_width  (width_reg),
        .image_height (height_reg),
        .q_count      (q_count),
        .push         (push),
        .work         (front_work)
    );

    k3c_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .wr_data  (front_work),
        .pop      (pop),
        .rd_valid (q_valid),
        .rd_data  (queue_work),
        .count    (q_count)
    );

    k3c_back #(
        .COEF_BITS (COEF_BITS)
    ) u_back (
        .clk               (clk),
        .rst_n             (rst_n),
        .kernel_row_top    (ktop_reg),
        .kernel_row_middle (kmid_reg),
        .kernel_row_bottom (kbot_reg),
        .q_valid           (q_valid),
        .work              (queue_work),
        .pop               (pop),
        .results           (results)
    );

endmodule
